// File: rtl/hlc_pkg.sv
// Shared types and constants for the handle LRU cache.
`timescale 1ns / 1ps
`default_nettype none

package hlc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int KEY_W       = 160;
  localparam int HANDLE_W    = 48;
  localparam int STAMP_W     = 64;
  localparam int INDEX_W     = 6;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [STAMP_W-1:0]  stamp_t;

  typedef struct packed {
    logic        command;
    logic        advance_tick;
    logic [31:0] key_text_hash;
    logic [31:0] key_text_length;
    logic [31:0] key_style_hash;
    logic [31:0] key_width_bits;
    logic [31:0] key_height_bits;
    handle_t     new_handle;
  } req_t;

  typedef struct packed {
    logic               hit;
    handle_t            found_handle;
    logic [INDEX_W-1:0] entry_index;
    logic               evicted;
    handle_t            evicted_handle;
  } rsp_t;

  // Key and handle share one memory word.
  typedef struct packed {
    key_t    key;
    handle_t handle;
  } ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/hlc_store.sv
// Entry storage: key/handle memory and stamp memory, one registered read port each.
`timescale 1ns / 1ps
`default_nettype none

module hlc_store #(
  parameter int ENTRIES = hlc_pkg::ENTRIES_DEF,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output hlc_pkg::ent_t        rd_entry,
  output hlc_pkg::stamp_t      rd_stamp,
  input  wire logic            ent_we,
  input  wire logic            stamp_we,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire hlc_pkg::ent_t   wr_entry,
  input  wire hlc_pkg::stamp_t wr_stamp
);

  hlc_pkg::ent_t   ent_mem   [ENTRIES];
  hlc_pkg::stamp_t stamp_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (rd_en) begin
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/handle_lru_cache_core.sv
// Top level of the handle LRU cache: request control, entry scan and result.
// Scan: a lookup hit ends the scan at the matching entry; a miss and an insert read every
// entry, one memory read per entry, and an insert then writes its chosen slot.
// Throughput: one request at a time; busy is low in the cycle done pulses.
// Reset (rst, synchronous): all entries invalid, use counter zero, no result pending.
// The receiver cannot stall: each result shows on result for the one cycle done is high.
`timescale 1ns / 1ps
`default_nettype none

module handle_lru_cache_core #(
  parameter int ENTRIES = hlc_pkg::ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire hlc_pkg::req_t request,
  output logic        done,
  output hlc_pkg::rsp_t result
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  hlc_pkg::state_t state, state_next;

  hlc_pkg::req_t   req;
  hlc_pkg::stamp_t use_counter;
  logic [ENTRIES-1:0] valid;

  logic [IDX_W-1:0] addr;
  logic             issued_all;
  logic             pipe_vld;
  logic [IDX_W-1:0] rd_idx;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             best_set;
  logic [IDX_W-1:0] best_idx;
  hlc_pkg::stamp_t  best_stamp;
  hlc_pkg::handle_t best_handle;

  hlc_pkg::ent_t    rd_entry;
  hlc_pkg::stamp_t  rd_stamp;
  hlc_pkg::key_t    req_key;

  logic             accept;
  logic             issue;
  logic             eval;
  logic             last_eval;
  logic             rd_valid;
  logic             match;
  logic             lookup_hit;
  logic             lookup_miss;
  logic             insert_go;
  logic             ent_we;
  logic             stamp_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] slot;
  hlc_pkg::ent_t    wr_entry;

  assign req_key = {req.key_text_hash, req.key_text_length, req.key_style_hash,
                    req.key_width_bits, req.key_height_bits};

  assign rd_valid  = valid[rd_idx];
  assign match     = rd_valid && (rd_entry.key == req_key);
  assign slot      = free_found ? free_idx : best_idx;
  assign wr_entry  = '{key: req_key, handle: req.new_handle};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      hlc_pkg::ST_IDLE: begin
        if (start) state_next = hlc_pkg::ST_SCAN;
      end
      hlc_pkg::ST_SCAN: begin
        if (pipe_vld) begin
          if (req.command == hlc_pkg::CMD_LOOKUP) begin
            if (match || rd_idx == LAST_IDX) state_next = hlc_pkg::ST_IDLE;
          end else if (rd_idx == LAST_IDX) begin
            state_next = hlc_pkg::ST_WRITE;
          end
        end
      end
      hlc_pkg::ST_WRITE: state_next = hlc_pkg::ST_IDLE;
      default: state_next = hlc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy        = (state != hlc_pkg::ST_IDLE);
    accept      = start && !busy;
    issue       = (state == hlc_pkg::ST_SCAN) && !issued_all;
    eval        = (state == hlc_pkg::ST_SCAN) && pipe_vld;
    last_eval   = eval && (rd_idx == LAST_IDX);
    lookup_hit  = eval && (req.command == hlc_pkg::CMD_LOOKUP) && match;
    lookup_miss = last_eval && (req.command == hlc_pkg::CMD_LOOKUP) && !match;
    insert_go   = (state == hlc_pkg::ST_WRITE);
    ent_we      = insert_go;
    stamp_we    = insert_go || lookup_hit;
    wr_addr     = insert_go ? slot : rd_idx;
  end

  hlc_store #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (addr),
    .rd_entry(rd_entry),
    .rd_stamp(rd_stamp),
    .ent_we  (ent_we),
    .stamp_we(stamp_we),
    .wr_addr (wr_addr),
    .wr_entry(wr_entry),
    .wr_stamp(use_counter)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hlc_pkg::ST_IDLE;
      use_counter <= '0;
      valid       <= '0;
      pipe_vld    <= 1'b0;
      done        <= 1'b0;
    end else begin
      state    <= state_next;
      pipe_vld <= issue;
      done     <= lookup_hit || lookup_miss || insert_go;
      if (accept && request.advance_tick) begin
        use_counter <= use_counter + 64'd1;
      end
      if (insert_go) begin
        valid[slot] <= 1'b1;
      end
    end
  end

  // Scan bookkeeping and result payload.
  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (accept) begin
      req        <= request;
      addr       <= '0;
      issued_all <= 1'b0;
      free_found <= 1'b0;
      best_set   <= 1'b0;
    end else begin
      if (issue) begin
        if (addr == LAST_IDX) begin
          issued_all <= 1'b1;
        end else begin
          addr <= addr + IDX_W'(1);
        end
      end
      if (eval && req.command == hlc_pkg::CMD_INSERT) begin
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        // Strict compare keeps the lowest index on a tie.
        if (rd_valid && (!best_set || rd_stamp < best_stamp)) begin
          best_set    <= 1'b1;
          best_idx    <= rd_idx;
          best_stamp  <= rd_stamp;
          best_handle <= rd_entry.handle;
        end
      end
    end

    if (lookup_hit) begin
      result <= '{hit: 1'b1, found_handle: rd_entry.handle,
                  entry_index: hlc_pkg::INDEX_W'(rd_idx),
                  evicted: 1'b0, evicted_handle: '0};
    end else if (lookup_miss) begin
      result <= '0;
    end else if (insert_go) begin
      result <= '{hit: 1'b0, found_handle: '0,
                  entry_index: hlc_pkg::INDEX_W'(slot),
                  evicted: !free_found,
                  evicted_handle: free_found ? '0 : best_handle};
    end
  end

  a_done_pulse : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  a_done_idle : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result delivered while still busy");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
      start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_hit_no_evict : assert property (@(posedge clk) disable iff (rst)
      done && result.hit |-> !result.evicted)
    else $error("result reports both hit and eviction");

  a_write_sets_valid : assert property (@(posedge clk) disable iff (rst)
      state == hlc_pkg::ST_WRITE |=> valid[$past(slot)])
    else $error("insert left its entry invalid");

endmodule

`default_nettype wire
